// ----- sv/pts_pkg.sv -----
// ---------------------------------------------------------------------------
// pts_pkg
// Types and constants shared by the priority task scheduler.
// ---------------------------------------------------------------------------
package pts_pkg;

  localparam logic [4:0] NO_TASK = 5'd16;

  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_INIT      = 3'd1,
    ACT_ACTIVATE  = 3'd2,
    ACT_TERMINATE = 3'd3,
    ACT_CHAIN     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    RS_SUSPENDED = 2'd0,
    RS_READY     = 2'd1,
    RS_RUNNING   = 2'd2
  } run_state_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_DUP    = 2'd1,
    STS_NO_RUN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_RD_RUN,
    FSM_TERM_WR,
    FSM_RD_ID,
    FSM_ID_WR,
    FSM_SCAN,
    FSM_SCAN_END,
    FSM_DECIDE,
    FSM_WR_OLD,
    FSM_WR_NEW,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] task_id;
    logic [7:0] priority_req;
    logic       autostart;
  } in_word_t;

  typedef struct packed {
    logic [4:0] running_task;
    logic       dispatched;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic       created;
    logic [7:0] prio;
    logic       autostart;
    run_state_e run_state;
    logic       activated;
  } slot_ent_t;

endpackage

// ----- sv/priority_task_scheduler.sv -----
// ---------------------------------------------------------------------------
// priority_task_scheduler
// Fixed-priority preemptive task manager over a table of task slots.
// ---------------------------------------------------------------------------
// One service request word in, one result word out. The slot table sits in a
// synchronous memory with one read and one write port. Create does not sweep
// the table. Every other defined action sweeps the whole table once, through
// the one read port, to pick the ready task of highest nonzero priority;
// action codes outside the defined set skip the sweep. Init rewrites the run
// states during the same sweep. A new request is taken once the previous one
// has reached the output register.
module priority_task_scheduler #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pts_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pts_pkg::out_word_t   out_word_o
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  pts_pkg::fsm_e      state_q, state_d;
  pts_pkg::in_word_t  in_q;
  pts_pkg::out_word_t out_q;
  logic               out_valid_q;

  logic [4:0]         run_q;
  logic               disp_q;
  logic [1:0]         status_q;

  pts_pkg::slot_ent_t mem_q [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] valid_q;
  pts_pkg::slot_ent_t rd_data_q;
  logic               rd_vld_q;

  logic [SLOT_W-1:0]  scan_q;
  logic [SLOT_W-1:0]  pidx_q;
  logic               pend_q;
  logic               found_q;
  logic [7:0]         bestp_q;
  logic [SLOT_W-1:0]  best_q;
  logic [7:0]         runp_q;
  pts_pkg::slot_ent_t best_ent_q;
  pts_pkg::slot_ent_t run_ent_q;

  logic               we;
  logic [SLOT_W-1:0]  wa;
  pts_pkg::slot_ent_t wd;
  logic [SLOT_W-1:0]  rd_addr;

  pts_pkg::slot_ent_t ent;
  pts_pkg::slot_ent_t eff;
  logic               id_ok;
  logic               run_valid;
  logic [SLOT_W-1:0]  id_slot;
  logic [SLOT_W-1:0]  run_slot;
  logic               is_init;
  logic               proc;
  logic               dispatch;
  logic               out_free;
  logic               term_hit;

  assign ent       = rd_vld_q ? rd_data_q : '0;
  assign id_ok     = 32'(in_q.task_id) < TASK_SLOTS;
  assign run_valid = (run_q != pts_pkg::NO_TASK) && (32'(run_q) < TASK_SLOTS);
  assign id_slot   = SLOT_W'(in_q.task_id);
  assign run_slot  = SLOT_W'(run_q);
  assign is_init   = in_q.action == pts_pkg::ACT_INIT;
  assign proc      = ((state_q == pts_pkg::FSM_SCAN) && pend_q) ||
                     (state_q == pts_pkg::FSM_SCAN_END);
  assign dispatch  = found_q && !(run_valid && (runp_q >= bestp_q));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign term_hit  = (in_q.action == pts_pkg::ACT_TERMINATE) ||
                     (ent.run_state == pts_pkg::RS_RUNNING);

  always_comb begin
    eff = ent;
    if (is_init) begin
      eff.run_state = ent.autostart ? pts_pkg::RS_READY : pts_pkg::RS_SUSPENDED;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = pts_pkg::FSM_DECODE;
      end
      pts_pkg::FSM_DECODE: begin
        case (in_q.action)
          pts_pkg::ACT_CREATE:   state_d = id_ok ? pts_pkg::FSM_RD_ID : pts_pkg::FSM_DONE;
          pts_pkg::ACT_INIT:     state_d = pts_pkg::FSM_SCAN;
          pts_pkg::ACT_ACTIVATE: state_d = id_ok ? pts_pkg::FSM_RD_ID : pts_pkg::FSM_SCAN;
          pts_pkg::ACT_TERMINATE: begin
            state_d = run_valid ? pts_pkg::FSM_RD_RUN : pts_pkg::FSM_SCAN;
          end
          pts_pkg::ACT_CHAIN: begin
            if (run_valid) state_d = pts_pkg::FSM_RD_RUN;
            else if (id_ok) state_d = pts_pkg::FSM_RD_ID;
            else state_d = pts_pkg::FSM_SCAN;
          end
          default: state_d = pts_pkg::FSM_DONE;
        endcase
      end
      pts_pkg::FSM_RD_RUN: state_d = pts_pkg::FSM_TERM_WR;
      pts_pkg::FSM_TERM_WR: begin
        if ((in_q.action == pts_pkg::ACT_CHAIN) && id_ok) state_d = pts_pkg::FSM_RD_ID;
        else state_d = pts_pkg::FSM_SCAN;
      end
      pts_pkg::FSM_RD_ID: state_d = pts_pkg::FSM_ID_WR;
      pts_pkg::FSM_ID_WR: begin
        if (in_q.action == pts_pkg::ACT_CREATE) state_d = pts_pkg::FSM_DONE;
        else state_d = pts_pkg::FSM_SCAN;
      end
      pts_pkg::FSM_SCAN: begin
        if (scan_q == LAST_SLOT) state_d = pts_pkg::FSM_SCAN_END;
      end
      pts_pkg::FSM_SCAN_END: state_d = pts_pkg::FSM_DECIDE;
      pts_pkg::FSM_DECIDE: begin
        if (!dispatch) state_d = pts_pkg::FSM_DONE;
        else if (run_valid) state_d = pts_pkg::FSM_WR_OLD;
        else state_d = pts_pkg::FSM_WR_NEW;
      end
      pts_pkg::FSM_WR_OLD: state_d = pts_pkg::FSM_WR_NEW;
      pts_pkg::FSM_WR_NEW: state_d = pts_pkg::FSM_DONE;
      pts_pkg::FSM_DONE: begin
        if (out_free) state_d = pts_pkg::FSM_IDLE;
      end
      default: state_d = pts_pkg::FSM_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    we      = 1'b0;
    wa      = '0;
    wd      = ent;
    rd_addr = '0;
    case (state_q)
      pts_pkg::FSM_RD_RUN: rd_addr = run_slot;
      pts_pkg::FSM_RD_ID:  rd_addr = id_slot;
      pts_pkg::FSM_TERM_WR: begin
        we           = term_hit;
        wa           = run_slot;
        wd.run_state = pts_pkg::RS_SUSPENDED;
        wd.activated = 1'b0;
      end
      pts_pkg::FSM_ID_WR: begin
        wa = id_slot;
        if (in_q.action == pts_pkg::ACT_CREATE) begin
          we           = !ent.created;
          wd.created   = 1'b1;
          wd.prio      = in_q.priority_req;
          wd.autostart = in_q.autostart;
          wd.run_state = pts_pkg::RS_SUSPENDED;
          wd.activated = 1'b0;
        end else begin
          we = 1'b1;
          if (!ent.activated && (ent.run_state == pts_pkg::RS_SUSPENDED)) begin
            wd.run_state = pts_pkg::RS_READY;
            wd.activated = 1'b1;
          end else begin
            wd.run_state = pts_pkg::RS_SUSPENDED;
            wd.activated = 1'b0;
          end
        end
      end
      pts_pkg::FSM_SCAN, pts_pkg::FSM_SCAN_END: begin
        rd_addr = scan_q;
        we      = proc && is_init;
        wa      = pidx_q;
        wd      = eff;
      end
      pts_pkg::FSM_WR_OLD: begin
        we           = 1'b1;
        wa           = run_slot;
        wd           = run_ent_q;
        wd.run_state = pts_pkg::RS_READY;
      end
      pts_pkg::FSM_WR_NEW: begin
        we           = 1'b1;
        wa           = best_q;
        wd           = best_ent_q;
        wd.run_state = pts_pkg::RS_RUNNING;
      end
      default: ;
    endcase
  end

  // slot table
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) valid_q[wa] <= 1'b1;
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::FSM_IDLE;
      run_q       <= pts_pkg::NO_TASK;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      bestp_q     <= '0;
      disp_q      <= 1'b0;
      status_q    <= pts_pkg::STS_OK;
    end else begin
      state_q <= state_d;
      pend_q  <= state_q == pts_pkg::FSM_SCAN;
      scan_q  <= (state_q == pts_pkg::FSM_SCAN) ? scan_q + SLOT_W'(1) : '0;

      if (state_q == pts_pkg::FSM_IDLE) begin
        found_q  <= 1'b0;
        bestp_q  <= '0;
        disp_q   <= 1'b0;
        status_q <= pts_pkg::STS_OK;
      end

      if (state_q == pts_pkg::FSM_DECODE) begin
        if ((in_q.action == pts_pkg::ACT_CREATE) && !id_ok) status_q <= pts_pkg::STS_DUP;
        if ((in_q.action == pts_pkg::ACT_TERMINATE) && !run_valid) begin
          status_q <= pts_pkg::STS_NO_RUN;
        end
      end

      if ((state_q == pts_pkg::FSM_ID_WR) && (in_q.action == pts_pkg::ACT_CREATE) &&
          ent.created) begin
        status_q <= pts_pkg::STS_DUP;
      end

      if ((state_q == pts_pkg::FSM_TERM_WR) && term_hit) run_q <= pts_pkg::NO_TASK;

      if (proc && (eff.run_state == pts_pkg::RS_READY) && (eff.prio > bestp_q)) begin
        found_q <= 1'b1;
        bestp_q <= eff.prio;
      end

      if (state_q == pts_pkg::FSM_WR_NEW) begin
        run_q  <= 5'(best_q);
        disp_q <= 1'b1;
      end

      if ((state_q == pts_pkg::FSM_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if ((state_q == pts_pkg::FSM_IDLE) && in_valid_i) in_q <= in_word_i;
    if (state_q == pts_pkg::FSM_SCAN) pidx_q <= scan_q;
    if (proc) begin
      if (run_valid && (pidx_q == run_slot)) begin
        run_ent_q <= eff;
        runp_q    <= eff.prio;
      end
      if ((eff.run_state == pts_pkg::RS_READY) && (eff.prio > bestp_q)) begin
        best_q     <= pidx_q;
        best_ent_q <= eff;
      end
    end
    if ((state_q == pts_pkg::FSM_DONE) && out_free) begin
      out_q.running_task <= run_q;
      out_q.dispatched   <= disp_q;
      out_q.status       <= status_q;
    end
  end

  assign in_stall_o  = state_q != pts_pkg::FSM_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
